FILE: hw/rtl/bsmg_pkg.sv
// ----------------------------------------------------------------------------
// bsmg_pkg
// Shared constants, types and helpers for the bounded set gap/range block.
// ----------------------------------------------------------------------------
package bsmg_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int DATA_W      = 32;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int CAP_W       = 7;
   localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   // register index, taken from the word address
   localparam logic REG_CAPACITY_LIMIT = 1'b0;

   typedef struct packed {
      logic load;     // latch new value and its full flag
      logic scan;     // read next stored entry
      logic update;   // store value, update min/max/count
      logic finish;   // load result register
   } ctrl_cmd_type;

   typedef struct packed {
      logic full;
      logic count_zero;
      logic scan_last;
      logic out_free;
   } dp_status_type;

   // unsigned distance between two signed values
   function automatic logic [DATA_W-1:0] distance(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
      logic [DATA_W:0] diff;
      diff = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      if (diff[DATA_W]) begin
         diff = -diff;
      end
      return diff[DATA_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/bsmg_ctrl.sv
// ----------------------------------------------------------------------------
// bsmg_ctrl
// Sequencer: accept, scan and update (skipped when full), hand result out.
// ----------------------------------------------------------------------------
module bsmg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bsmg_pkg::dp_status_type status,
   output bsmg_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               priority if (status.full) begin
                  state_in = ST_FINISH;
               end else if (status.count_zero) begin
                  state_in = ST_UPDATE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

FILE: hw/rtl/bsmg_dp.sv
// ----------------------------------------------------------------------------
// bsmg_dp
// Datapath: value store, running min/max/gap and the result register.
// ----------------------------------------------------------------------------
module bsmg_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  bsmg_pkg::ctrl_cmd_type              cmd,
   output bsmg_pkg::dp_status_type             status,
   input  logic [bsmg_pkg::CAP_W-1:0]          capacity,
   input  logic signed [bsmg_pkg::DATA_W-1:0]  new_value,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic                                add_status,
   output logic                                spans_valid,
   output logic [bsmg_pkg::DATA_W-1:0]         shortest_span,
   output logic [bsmg_pkg::DATA_W-1:0]         longest_span
);

   logic [bsmg_pkg::DATA_W-1:0] mem [bsmg_pkg::MAX_ENTRIES];

   logic [bsmg_pkg::DATA_W-1:0] value_ff;
   logic                        full_ff;
   logic [bsmg_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [bsmg_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                        pending_ff;
   logic [bsmg_pkg::DATA_W-1:0] rd_data_ff;
   logic signed [bsmg_pkg::DATA_W-1:0] min_ff, min_in;
   logic signed [bsmg_pkg::DATA_W-1:0] max_ff, max_in;
   logic [bsmg_pkg::DATA_W-1:0] gap_ff, gap_in;

   logic                        rsp_valid_ff;
   logic                        status_ff;
   logic                        spans_valid_ff;
   logic [bsmg_pkg::DATA_W-1:0] shortest_ff;
   logic [bsmg_pkg::DATA_W-1:0] longest_ff;

   logic [bsmg_pkg::CMP_W-1:0]  cap_ext;
   logic [bsmg_pkg::CMP_W-1:0]  cap_sat;
   logic [bsmg_pkg::CMP_W-1:0]  count_ext;
   logic [bsmg_pkg::CNT_W-1:0]  count_m1;
   logic [bsmg_pkg::CNT_W-1:0]  idx_ext;
   logic [bsmg_pkg::DATA_W-1:0] gap_cand;
   logic signed [bsmg_pkg::DATA_W-1:0] value_s;

   // capacity above the store size saturates
   always_comb begin
      cap_ext   = bsmg_pkg::CMP_W'(capacity);
      count_ext = bsmg_pkg::CMP_W'(count_ff);
      if (cap_ext > bsmg_pkg::CMP_W'(bsmg_pkg::MAX_ENTRIES)) begin
         cap_sat = bsmg_pkg::CMP_W'(bsmg_pkg::MAX_ENTRIES);
      end else begin
         cap_sat = cap_ext;
      end
   end

   assign count_m1 = count_ff - bsmg_pkg::CNT_W'(1);
   assign idx_ext  = bsmg_pkg::CNT_W'(idx_ff);
   assign value_s  = value_ff;

   assign status.full       = (count_ext >= cap_sat);
   assign status.count_zero = (count_ff == '0);
   assign status.scan_last  = (idx_ext == count_m1);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign gap_cand = bsmg_pkg::distance(value_ff, rd_data_ff);

   always_comb begin
      idx_in   = idx_ff;
      gap_in   = gap_ff;
      count_in = count_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.scan) begin
         idx_in = idx_ff + bsmg_pkg::IDX_W'(1);
      end
      // compare lands in the cycle after its read
      if (pending_ff && (gap_cand < gap_ff)) begin
         gap_in = gap_cand;
      end
      if (cmd.update) begin
         count_in = count_ff + bsmg_pkg::CNT_W'(1);
         if (count_ff == '0) begin
            min_in = value_s;
            max_in = value_s;
         end else begin
            if (value_s < min_ff) begin
               min_in = value_s;
            end
            if (value_s > max_ff) begin
               max_in = value_s;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
         gap_ff     <= '1;
         pending_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         gap_ff     <= gap_in;
         pending_ff <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         value_ff <= new_value;
         full_ff  <= status.full;
      end
   end

   // value store
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         mem[count_ff[bsmg_pkg::IDX_W-1:0]] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         status_ff <= full_ff;
         if (count_ff >= bsmg_pkg::CNT_W'(2)) begin
            spans_valid_ff <= 1'b1;
            shortest_ff    <= gap_ff;
            longest_ff     <= max_ff - min_ff;
         end else begin
            spans_valid_ff <= 1'b0;
            shortest_ff    <= '0;
            longest_ff     <= '0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign add_status    = status_ff;
   assign spans_valid   = spans_valid_ff;
   assign shortest_span = shortest_ff;
   assign longest_span  = longest_ff;

endmodule

FILE: hw/rtl/bounded_set_min_gap_and_range.sv
// Flow: an accepted value is compared against the stored entries by a scan that reads
// each stored entry once, then stored; a rejected value goes straight to the result.
// A new item is taken only once the previous result has been handed to the output
// (req_stall is high until then), so a result held by rsp_stall delays the next item
// for as long as it waits.
// Reset (synchronous): empties the set, capacity 0, gap all ones; store contents
// are left as they are and never read before written.
// ----------------------------------------------------------------------------
// bounded_set_min_gap_and_range
// Bounded signed value set reporting minimum gap and range after each item.
// ----------------------------------------------------------------------------
module bounded_set_min_gap_and_range (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [bsmg_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [bsmg_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [bsmg_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [bsmg_pkg::DATA_W-1:0]    req_new_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_add_status,
   output logic                                  rsp_spans_valid,
   output logic [bsmg_pkg::DATA_W-1:0]           rsp_shortest_span,
   output logic [bsmg_pkg::DATA_W-1:0]           rsp_longest_span
);

   logic [bsmg_pkg::CAP_W-1:0] capacity_ff;
   logic                       csr_write;
   bsmg_pkg::ctrl_cmd_type     cmd;
   bsmg_pkg::dp_status_type    status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
      end else if (csr_write && (csr_paddr[2] == bsmg_pkg::REG_CAPACITY_LIMIT)) begin
         capacity_ff <= csr_pwdata[bsmg_pkg::CAP_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == bsmg_pkg::REG_CAPACITY_LIMIT) begin
         csr_prdata = bsmg_pkg::CSR_DATA_W'(capacity_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   bsmg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bsmg_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .capacity      (capacity_ff),
      .new_value     (req_new_value),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .add_status    (rsp_add_status),
      .spans_valid   (rsp_spans_valid),
      .shortest_span (rsp_shortest_span),
      .longest_span  (rsp_longest_span)
   );

endmodule
